// ===== rtl/afrc_pkg.sv =====
// Shared types and constants for the audio frame rate converter.
package afrc_pkg;

  // Configuration port geometry.
  localparam int ADDR_W     = 5;
  localparam int CFG_DATA_W = 32;

  // Configuration field widths.
  localparam int DEC_W       = 4;
  localparam int FRAME_OUT_W = 10;
  localparam int FRAME_IN_W  = 12;
  localparam int STEP_W      = 28;

  // Register indexes (byte address divided by four).
  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_CHANNELS  = 3'd1;
  localparam logic [2:0] REG_DEC       = 3'd2;
  localparam logic [2:0] REG_FRAME_OUT = 3'd3;
  localparam logic [2:0] REG_FRAME_IN  = 3'd4;
  localparam logic [2:0] REG_STEP      = 3'd5;

  // Register reset values.
  localparam logic                   RST_MODE      = 1'b0;
  localparam logic [1:0]             RST_CHANNELS  = 2'd1;
  localparam logic [DEC_W-1:0]       RST_DEC       = 4'd1;
  localparam logic [FRAME_OUT_W-1:0] RST_FRAME_OUT = 10'd640;
  localparam logic [FRAME_IN_W-1:0]  RST_FRAME_IN  = 12'd1764;
  localparam logic [STEP_W-1:0]      RST_STEP      = 28'd180813;

  // Operating modes.
  localparam logic MODE_DECIMATE    = 1'b0;
  localparam logic MODE_INTERPOLATE = 1'b1;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic                   mode;
    logic [1:0]             channels;
    logic [DEC_W-1:0]       decimation_factor;
    logic [FRAME_OUT_W-1:0] frame_out_len;
    logic [FRAME_IN_W-1:0]  frame_in_len;
    logic [STEP_W-1:0]      step_q16;
  } cfg_t;

endpackage

// ===== rtl/afrc_cfg.sv =====
// APB-style configuration register file for the audio frame rate converter.
module afrc_cfg
  import afrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [2:0] reg_index;
  logic       wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign wr_en     = psel && penable && pwrite && pready;

  // Register writes on the access phase of a write transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode              <= RST_MODE;
      cfg.channels          <= RST_CHANNELS;
      cfg.decimation_factor <= RST_DEC;
      cfg.frame_out_len     <= RST_FRAME_OUT;
      cfg.frame_in_len      <= RST_FRAME_IN;
      cfg.step_q16          <= RST_STEP;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_MODE:      cfg.mode              <= pwdata[0];
        REG_CHANNELS:  cfg.channels          <= pwdata[1:0];
        REG_DEC:       cfg.decimation_factor <= pwdata[DEC_W-1:0];
        REG_FRAME_OUT: cfg.frame_out_len     <= pwdata[FRAME_OUT_W-1:0];
        REG_FRAME_IN:  cfg.frame_in_len      <= pwdata[FRAME_IN_W-1:0];
        REG_STEP:      cfg.step_q16          <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    unique case (reg_index)
      REG_MODE:      prdata = CFG_DATA_W'(cfg.mode);
      REG_CHANNELS:  prdata = CFG_DATA_W'(cfg.channels);
      REG_DEC:       prdata = CFG_DATA_W'(cfg.decimation_factor);
      REG_FRAME_OUT: prdata = CFG_DATA_W'(cfg.frame_out_len);
      REG_FRAME_IN:  prdata = CFG_DATA_W'(cfg.frame_in_len);
      REG_STEP:      prdata = CFG_DATA_W'(cfg.step_q16);
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== rtl/afrc_lerp.sv =====
// Linear interpolation between two samples with a rounded weighted difference.
module afrc_lerp #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic signed [SAMPLE_WIDTH-1:0] a,
  input  logic signed [SAMPLE_WIDTH-1:0] b,
  input  logic        [FRAC_BITS-1:0]    fr,
  output logic signed [SAMPLE_WIDTH-1:0] y
);

  localparam int PW = SAMPLE_WIDTH + FRAC_BITS + 2;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

  logic signed [SAMPLE_WIDTH:0]   diff;
  logic signed [FRAC_BITS:0]      weight;
  logic signed [PW-1:0]           prod;
  logic signed [PW-1:0]           rounded;
  logic signed [SAMPLE_WIDTH:0]   delta;
  logic signed [SAMPLE_WIDTH:0]   sum;

  // a + round(fr * (b - a)); the result always lies between a and b, so the
  // low bits of the sum are the exact value.
  always_comb begin
    diff    = {b[SAMPLE_WIDTH-1], b} - {a[SAMPLE_WIDTH-1], a};
    weight  = {1'b0, fr};
    prod    = diff * weight;
    rounded = (prod + HALF) >>> FRAC_BITS;
    delta   = rounded[SAMPLE_WIDTH:0];
    sum     = {a[SAMPLE_WIDTH-1], a} + delta;
    y       = sum[SAMPLE_WIDTH-1:0];
  end

endmodule

// ===== rtl/afrc_core.sv =====
// Per-sample state and output decision for decimate and interpolate modes.
module afrc_core
  import afrc_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cfg_t                           cfg,
  input  logic                           fire,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic                           emit,
  output logic                           last,
  output logic signed [SAMPLE_WIDTH-1:0] value
);

  localparam int POS_W = FRAME_IN_W + FRAC_BITS;
  localparam int SUM_W = ((POS_W > STEP_W) ? POS_W : STEP_W) + 1;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // State registers.
  logic                           channel_phase;
  logic [DEC_W-1:0]               decimation_phase;
  logic [FRAME_IN_W-1:0]          input_index;
  logic [POS_W-1:0]               next_position;
  logic [FRAME_OUT_W-1:0]         output_count;
  logic signed [SAMPLE_WIDTH-1:0] previous_sample;

  logic [DEC_W-1:0]       factor;
  logic                   take;
  logic [DEC_W:0]         dec_inc;
  logic                   dec_wrap;
  logic [FRAME_OUT_W:0]   cnt_inc;
  logic                   frame_full;
  logic                   ch0;
  logic [FRAME_IN_W-1:0]  in_len;
  logic [FRAME_IN_W:0]    idx_inc;
  logic                   at_end;
  logic [FRAME_IN_W-1:0]  lo;
  logic [FRAC_BITS-1:0]   fr;
  logic                   match;
  logic                   use_lerp;
  logic                   i_emit;
  logic [SUM_W-1:0]       pos_sum;
  logic [POS_W-1:0]       pos_sat;
  logic signed [SAMPLE_WIDTH-1:0] lerp_y;

  afrc_lerp #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_lerp (
    .a (previous_sample),
    .b (sample),
    .fr(fr),
    .y (lerp_y)
  );

  // Decision logic for the sample now leaving the input register.
  always_comb begin
    factor     = (cfg.decimation_factor == '0) ? DEC_W'(1) : cfg.decimation_factor;
    take       = (decimation_phase == '0);
    dec_inc    = {1'b0, decimation_phase} + (DEC_W+1)'(1);
    dec_wrap   = dec_inc >= {1'b0, factor};
    cnt_inc    = {1'b0, output_count} + (FRAME_OUT_W+1)'(1);
    frame_full = cnt_inc >= {1'b0, cfg.frame_out_len};
    ch0        = !channel_phase;
    in_len     = (cfg.frame_in_len == '0) ? FRAME_IN_W'(1) : cfg.frame_in_len;
    idx_inc    = {1'b0, input_index} + (FRAME_IN_W+1)'(1);
    at_end     = idx_inc >= {1'b0, in_len};
    lo         = next_position[POS_W-1:FRAC_BITS];
    fr         = next_position[FRAC_BITS-1:0];
    if (fr == '0) begin
      match = (lo == input_index);
    end else begin
      match = (({1'b0, lo} + (FRAME_IN_W+1)'(1)) == {1'b0, input_index});
    end
    use_lerp = match && (fr != '0);
    i_emit   = ch0 && (output_count < cfg.frame_out_len) && (match || at_end);
    pos_sum  = SUM_W'(next_position) + SUM_W'(cfg.step_q16);
    pos_sat  = (pos_sum > SUM_W'(POS_MAX)) ? POS_MAX : pos_sum[POS_W-1:0];

    if (cfg.mode == MODE_DECIMATE) begin
      emit  = take && (cfg.frame_out_len != '0);
      last  = frame_full;
      value = sample;
    end else begin
      emit  = i_emit;
      last  = at_end || frame_full;
      value = use_lerp ? lerp_y : sample;
    end
  end

  // State update, one sample per fire.
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_phase    <= 1'b0;
      decimation_phase <= '0;
      input_index      <= '0;
      next_position    <= '0;
      output_count     <= '0;
      previous_sample  <= '0;
    end else if (fire) begin
      if (cfg.mode == MODE_DECIMATE) begin
        decimation_phase <= dec_wrap ? '0 : dec_inc[DEC_W-1:0];
        if (emit) begin
          output_count <= frame_full ? '0 : cnt_inc[FRAME_OUT_W-1:0];
        end
      end else begin
        channel_phase <= (cfg.channels >= 2'd2) ? ~channel_phase : 1'b0;
        if (ch0) begin
          if (at_end) begin
            input_index     <= '0;
            next_position   <= '0;
            output_count    <= '0;
            previous_sample <= '0;
          end else begin
            input_index     <= idx_inc[FRAME_IN_W-1:0];
            previous_sample <= sample;
            if (i_emit) begin
              output_count  <= cnt_inc[FRAME_OUT_W-1:0];
              next_position <= pos_sat;
            end
          end
        end
      end
    end
  end

  // The end of an input frame leaves the interpolation state cleared.
  a_frame_end_clears: assert property (@(posedge clk) disable iff (rst)
    fire && (cfg.mode == MODE_INTERPOLATE) && ch0 && at_end
    |=> (input_index == '0) && (next_position == '0) && (output_count == '0))
    else $error("input frame end did not clear interpolation state");

  // Decimate mode never moves the channel phase.
  a_dec_keeps_phase: assert property (@(posedge clk) disable iff (rst)
    fire && (cfg.mode == MODE_DECIMATE) |=> channel_phase == $past(channel_phase))
    else $error("channel phase changed in decimate mode");

  // In interpolate mode, the second channel of a pair never produces a result.
  a_ch1_silent: assert property (@(posedge clk) disable iff (rst)
    (cfg.mode == MODE_INTERPOLATE) && channel_phase |-> !emit)
    else $error("result produced from a non-zero channel");

endmodule

// ===== rtl/audio_frame_rate_converter.sv =====
// Audio frame rate converter: input register, conversion core and output register.
// An input transfer is held in the input register, and its result in the output register.
// Throughput: one sample per cycle while the output port is not stalled; each sample yields zero or one result.
// The input register is freed whenever the output register is empty or drained.
// Reset (rst, synchronous, active high) clears both pipeline registers, the
// conversion state, and returns the configuration registers to their defaults.
module audio_frame_rate_converter
  import afrc_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,   // sample_in
  // Output stream.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_tdata,   // sample_out
  output logic                                m_tlast,   // frame_last
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ADDR_W-1:0]                   paddr,
  input  logic [CFG_DATA_W-1:0]               pwdata,
  output logic [CFG_DATA_W-1:0]               prdata,
  output logic                                pready
);

  localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

  cfg_t cfg;

  logic                           in_valid;
  logic signed [SAMPLE_WIDTH-1:0] in_sample;
  logic                           out_valid;
  logic signed [SAMPLE_WIDTH-1:0] out_sample;
  logic                           out_last;
  logic                           adv;
  logic                           core_emit;
  logic                           core_last;
  logic signed [SAMPLE_WIDTH-1:0] core_value;

  afrc_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  afrc_core #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .fire  (adv),
    .sample(in_sample),
    .emit  (core_emit),
    .last  (core_last),
    .value (core_value)
  );

  // The held sample moves on when the output register has room for its result.
  assign adv      = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_sample <= s_tdata[SAMPLE_WIDTH-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && core_emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && core_emit) begin
      out_sample <= core_value;
      out_last   <= core_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = TDATA_W'($unsigned(out_sample));
  assign m_tlast  = out_last;

  // A sample that cannot move on stays in the input register unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !adv |=> in_valid && $stable(in_sample))
    else $error("input register lost a stalled sample");

  // A result produced by the core is always presented on the next cycle.
  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    adv && core_emit |=> m_tvalid)
    else $error("core result not loaded into the output register");

endmodule

// ===== tb/sv/afrc_checker.sv =====
// Checker for the audio frame rate converter: predicts and checks output transfers and reads.
module afrc_checker
  import afrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Input stream, observed only.
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [15:0]           s_tdata,     // sample_in
  // Output stream, observed only.
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [15:0]           m_tdata,     // sample_out
  input  logic                  m_tlast,     // frame_last
  // Configuration port, observed only.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic [CFG_DATA_W-1:0] prdata,
  input  logic                  pready,
  // Status toward the testbench top.
  output int                    mismatches,
  output int                    outstanding,
  output int                    results_seen
);

  typedef struct packed {
    logic [15:0] sample;
    logic        last;
  } frame_sample_t;

  // Output samples predicted but not yet seen on the output port.
  frame_sample_t expected_samples[$];

  // Shadow copy of the configuration registers.
  cfg_t regs;

  // Conversion state.
  logic               chan_phase;
  logic [DEC_W-1:0]   dec_phase;
  logic [11:0]        in_idx;
  logic [STEP_W-1:0]  position;
  logic [9:0]         out_cnt;
  logic signed [15:0] prev_sample;

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    results_seen = 0;
  end

  // Linear blend of two Q1.15 samples with a 16-bit fraction, rounded half up.
  function automatic logic signed [15:0] blend_q15(input logic signed [15:0] a,
                                                   input logic signed [15:0] b,
                                                   input logic [15:0] frac);
    longint unsigned ua, ub, wa, acc;
    longint          mixed;
    ua    = longint'(a) + 32768;
    ub    = longint'(b) + 32768;
    wa    = 65536 - longint'(frac);
    acc   = wa * ua + longint'(frac) * ub + 32768;
    mixed = longint'(acc >> 16) - 32768;
    if (mixed > 32767) mixed = 32767;
    if (mixed < -32768) mixed = -32768;
    return 16'(mixed);
  endfunction

  // Current contents of a register as a read should return them.
  function automatic logic [CFG_DATA_W-1:0] reg_value(input logic [2:0] idx);
    logic [CFG_DATA_W-1:0] data;
    data = '0;
    case (idx)
      REG_MODE:      data[0] = regs.mode;
      REG_CHANNELS:  data[1:0] = regs.channels;
      REG_DEC:       data[DEC_W-1:0] = regs.decimation_factor;
      REG_FRAME_OUT: data[FRAME_OUT_W-1:0] = regs.frame_out_len;
      REG_FRAME_IN:  data[FRAME_IN_W-1:0] = regs.frame_in_len;
      REG_STEP:      data[STEP_W-1:0] = regs.step_q16;
      default:       data = '0;
    endcase
    return data;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_MODE:      regs.mode = data[0];
      REG_CHANNELS:  regs.channels = data[1:0];
      REG_DEC:       regs.decimation_factor = data[DEC_W-1:0];
      REG_FRAME_OUT: regs.frame_out_len = data[FRAME_OUT_W-1:0];
      REG_FRAME_IN:  regs.frame_in_len = data[FRAME_IN_W-1:0];
      REG_STEP:      regs.step_q16 = data[STEP_W-1:0];
      default:       ;
    endcase
  endtask

  // Advance the converter by one input sample and queue the output it yields, if any.
  task automatic convert_sample(input logic signed [15:0] x);
    int unsigned        factor, in_len;
    logic               take, last, ch0, at_end, match;
    logic [11:0]        lo;
    logic [15:0]        frac;
    logic [STEP_W:0]    next_pos;
    logic signed [15:0] value;
    if (regs.mode == MODE_DECIMATE) begin
      // Keep every factor-th interleaved sample; a zero factor acts as one.
      factor    = (regs.decimation_factor == 0) ? 1 : regs.decimation_factor;
      take      = (dec_phase == 0);
      dec_phase = (dec_phase + 1 >= factor) ? '0 : dec_phase + 1'b1;
      if (take && regs.frame_out_len != 0) begin
        last = (out_cnt + 1 >= regs.frame_out_len);
        expected_samples.push_back('{sample: x, last: last});
        out_cnt = last ? '0 : out_cnt + 1'b1;
      end
    end else begin
      // Only channel 0 takes part; a count of zero acts as one, three as two.
      ch0        = !chan_phase;
      chan_phase = (regs.channels >= 2) ? ~chan_phase : 1'b0;
      if (ch0) begin
        in_len = (regs.frame_in_len == 0) ? 1 : regs.frame_in_len;
        at_end = (in_idx + 1 >= in_len);
        lo     = position[STEP_W-1:16];
        frac   = position[15:0];
        match  = (frac == 0) ? (lo == in_idx) : (lo + 1 == in_idx);
        // The last sample of an input frame always closes an unfinished output frame.
        if (out_cnt < regs.frame_out_len && (match || at_end)) begin
          value    = (match && frac != 0) ? blend_q15(prev_sample, x, frac) : x;
          last     = at_end || (out_cnt + 1 >= regs.frame_out_len);
          expected_samples.push_back('{sample: value, last: last});
          out_cnt  = out_cnt + 1'b1;
          next_pos = {1'b0, position} + {1'b0, regs.step_q16};
          position = next_pos[STEP_W] ? '1 : next_pos[STEP_W-1:0];
        end
        if (at_end) begin
          in_idx      = '0;
          position    = '0;
          out_cnt     = '0;
          prev_sample = '0;
        end else begin
          in_idx      = in_idx + 1'b1;
          prev_sample = x;
        end
      end
    end
  endtask

  // Watch all three ports at each rising edge.
  always @(posedge clk) begin
    frame_sample_t want;
    if (rst) begin
      regs.mode              = RST_MODE;
      regs.channels          = RST_CHANNELS;
      regs.decimation_factor = RST_DEC;
      regs.frame_out_len     = RST_FRAME_OUT;
      regs.frame_in_len      = RST_FRAME_IN;
      regs.step_q16          = RST_STEP;
      chan_phase  = 1'b0;
      dec_phase   = '0;
      in_idx      = '0;
      position    = '0;
      out_cnt     = '0;
      prev_sample = '0;
      expected_samples.delete();
    end else begin
      // Register accesses.
      if (psel && penable && pready) begin
        if (pwrite) begin
          write_reg(paddr[4:2], pwdata);
        end else if (prdata !== reg_value(paddr[4:2])) begin
          mismatches++;
          $display("%0t: register read at 0x%0h: expected 0x%0h, got 0x%0h",
                   $time, paddr, reg_value(paddr[4:2]), prdata);
        end
      end
      // Output transfers against the oldest prediction.
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_samples.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected output: expected nothing, got sample %0d last %0b",
                   $time, $signed(m_tdata), m_tlast);
        end else begin
          want = expected_samples.pop_front();
          if (m_tdata !== want.sample || m_tlast !== want.last) begin
            mismatches++;
            $display("%0t: output mismatch: expected sample %0d last %0b, got sample %0d last %0b",
                     $time, $signed(want.sample), want.last, $signed(m_tdata), m_tlast);
          end
        end
      end
      // Input transfers feed the prediction.
      if (s_tvalid && s_tready) begin
        convert_sample(s_tdata);
      end
    end
    outstanding = expected_samples.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the audio frame rate converter: stimulus, stalls and the verdict.
module tb_top;
  import afrc_pkg::*;

  localparam int DATA_W        = 16;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 1550;

  typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_HALF, READY_EVERY_THIRD} stall_pattern_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [DATA_W-1:0]     s_tdata;   // sample_in
  logic                  m_tvalid;
  logic                  m_tready;
  logic [DATA_W-1:0]     m_tdata;   // sample_out
  logic                  m_tlast;   // frame_last
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int mismatches;
  int outstanding;
  int results_seen;
  int cycle_count   = 0;
  int items_sent    = 0;
  int config_phases = 0;
  int burst_left    = 0;
  bit hold_off_req  = 1'b0;

  audio_frame_rate_converter DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  afrc_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .mismatches(mismatches), .outstanding(outstanding), .results_seen(results_seen)
  );

  // Clock with a period of 12.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Cycle counter that ends a run that hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d output samples still due.",
               cycle_count, outstanding);
      $display("FAILURE");
      $finish;
    end
  end

  // Output side: stall patterns of varying length, and one long hold-off on request.
  initial begin
    stall_pattern_t pattern;
    int             span;
    m_tready <= 1'b0;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        @(posedge clk);
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      pattern = stall_pattern_t'($urandom_range(0, 3));
      span    = $urandom_range(10, 120);
      for (int i = 0; i < span && !hold_off_req; i++) begin
        @(posedge clk);
        case (pattern)
          READY_ALWAYS:  m_tready <= 1'b1;
          READY_MOSTLY:  m_tready <= ($urandom_range(0, 3) != 0);
          READY_HALF:    m_tready <= ($urandom_range(0, 1) != 0);
          default:       m_tready <= (i % 3 == 0);
        endcase
      end
    end
  end

  // One register write: setup phase, access phase, then idle.
  task automatic apb_write(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // One register read; the checker compares the returned data.
  task automatic apb_read(input logic [2:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Program every register, then read each one back.
  task automatic configure(input logic md, input logic [1:0] ch, input logic [3:0] dec,
                           input logic [9:0] out_len, input logic [11:0] in_len,
                           input logic [27:0] step);
    apb_write(REG_MODE, CFG_DATA_W'(md));
    apb_write(REG_CHANNELS, CFG_DATA_W'(ch));
    apb_write(REG_DEC, CFG_DATA_W'(dec));
    apb_write(REG_FRAME_OUT, CFG_DATA_W'(out_len));
    apb_write(REG_FRAME_IN, CFG_DATA_W'(in_len));
    apb_write(REG_STEP, CFG_DATA_W'(step));
    apb_read(REG_MODE);
    apb_read(REG_CHANNELS);
    apb_read(REG_DEC);
    apb_read(REG_FRAME_OUT);
    apb_read(REG_FRAME_IN);
    apb_read(REG_STEP);
    config_phases++;
  endtask

  // Offer one sample; the sender runs in bursts with random gaps between them.
  task automatic push_sample(input logic [DATA_W-1:0] value);
    logic accepted;
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) == 0) burst_left = $urandom_range(40, 150);
      else burst_left = $urandom_range(1, 12);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    // Ready is stable between the falling edge and the next rising edge.
    accepted = 1'b0;
    while (!accepted) begin
      @(negedge clk);
      accepted = s_tready;
      @(posedge clk);
    end
    items_sent++;
  endtask

  // Wait until every predicted output has arrived and the pipeline has emptied.
  task automatic drain();
    s_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_sample();
    case ($urandom_range(0, 11))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // One random configuration followed by mostly whole frames of random samples.
  task automatic random_phase();
    logic        md;
    logic [1:0]  ch;
    logic [3:0]  dec;
    logic [9:0]  out_len;
    logic [11:0] in_len;
    logic [27:0] step;
    int          in_eff, ch_eff, count;
    md = ($urandom_range(0, 99) < 65) ? MODE_INTERPOLATE : MODE_DECIMATE;
    ch = 2'($urandom_range(0, 3));
    dec = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 12));
    case ($urandom_range(0, 19))
      0:       out_len = ($urandom_range(0, 2) == 0) ? 10'd0 :
                         ($urandom_range(0, 1) == 0) ? 10'd1 : 10'd1023;
      1:       out_len = 10'($urandom_range(25, 300));
      default: out_len = 10'($urandom_range(2, 24));
    endcase
    case ($urandom_range(0, 19))
      0:       in_len = ($urandom_range(0, 2) == 0) ? 12'd0 :
                        ($urandom_range(0, 1) == 0) ? 12'd1 : 12'd4095;
      1:       in_len = 12'($urandom_range(25, 200));
      default: in_len = 12'($urandom_range(2, 24));
    endcase
    in_eff = (in_len == 0) ? 1 : in_len;
    ch_eff = (ch >= 2) ? 2 : 1;
    // Mostly the step that maps the input frame onto the output frame.
    if ($urandom_range(0, 4) != 0) begin
      step = (out_len > 1) ? 28'(((in_eff - 1) << 16) / (out_len - 1)) : 28'h10000;
    end else begin
      case ($urandom_range(0, 2))
        0:       step = 28'($urandom_range(0, 65535));
        1:       step = 28'hFFFFFFF;
        default: step = 28'($urandom());
      endcase
    end
    if (md == MODE_DECIMATE) begin
      count = $urandom_range(20, 120);
    end else begin
      count = $urandom_range(1, 4) * in_eff * ch_eff;
      if ($urandom_range(0, 3) == 0) count += $urandom_range(0, in_eff * ch_eff);
      if (count > 400) count = 400;
    end
    configure(md, ch, dec, out_len, in_len, step);
    repeat (count) push_sample(pick_sample());
    drain();
  endtask

  // Main sequence: reset, directed cases, long output stall, random phases.
  initial begin
    int directed_items;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults pass samples straight through; sample extremes.
    push_sample(16'h7FFF);
    push_sample(16'h8000);
    push_sample(16'hFFFF);
    drain();

    // A zero decimation factor acts as one; frames of two samples.
    configure(MODE_DECIMATE, 2'd1, 4'd0, 10'd2, 12'd4, 28'h10000);
    push_sample(16'h0001);
    push_sample(16'hFFFE);
    push_sample(16'h4000);
    drain();

    // A zero output frame length yields nothing.
    configure(MODE_DECIMATE, 2'd1, 4'd1, 10'd0, 12'd4, 28'h10000);
    push_sample(16'h1234);
    push_sample(16'h8765);
    drain();

    // A channel count of three acts as two; a zero input frame length acts as one.
    configure(MODE_INTERPOLATE, 2'd3, 4'd1, 10'd1023, 12'd0, 28'h10000);
    push_sample(16'h7FFF);
    push_sample(16'h8000);
    push_sample(16'h8000);
    push_sample(16'h7FFF);
    drain();

    // Channel count zero, step below one, and an output frame that fills early.
    configure(MODE_INTERPOLATE, 2'd0, 4'd1, 10'd2, 12'd3, 28'h08000);
    push_sample(16'h8000);
    push_sample(16'h7FFF);
    push_sample(16'h0000);
    drain();

    // The largest step puts the position at its maximum; the next result comes at the frame end.
    configure(MODE_INTERPOLATE, 2'd1, 4'd1, 10'd5, 12'd3, 28'hFFFFFFF);
    push_sample(16'h2222);
    push_sample(16'hDDDD);
    push_sample(16'h5555);
    drain();

    // Fractional step across full-scale swings on two interleaved channels.
    configure(MODE_INTERPOLATE, 2'd2, 4'd1, 10'd4, 12'd4, 28'h15555);
    push_sample(16'h7FFF);
    push_sample(16'h0F0F);
    push_sample(16'h8000);
    push_sample(16'hF0F0);
    push_sample(16'h7FFF);
    push_sample(16'hAAAA);
    push_sample(16'h8000);
    push_sample(16'h5555);
    drain();
    directed_items = items_sent;

    // Long output stall while the sender keeps offering samples.
    configure(MODE_DECIMATE, 2'd1, 4'd1, 10'd16, 12'd16, 28'h10000);
    hold_off_req = 1'b1;
    repeat (80) push_sample(pick_sample());
    drain();

    while (items_sent < directed_items + RANDOM_ITEMS) random_phase();

    $display("Converted %0d input samples in %0d register settings; %0d output samples checked.",
             items_sent, config_phases, results_seen);
    $display("Both modes, all channel counts and decimation factors, and a %0d-cycle stall ran.",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/afrc_pkg.sv
rtl/afrc_cfg.sv
rtl/afrc_lerp.sv
rtl/afrc_core.sv
rtl/audio_frame_rate_converter.sv
tb/sv/afrc_checker.sv
tb/sv/tb_top.sv
